[src/psd_pkg.sv]
package psd_pkg;

	localparam int COORD_W   = 16;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int DOT_W     = PROD_W + 1;
	localparam int LEN_W     = PROD_W;
	localparam int NUM_W     = 2 * LEN_W;
	localparam int QUO_W     = LEN_W;
	localparam int HALF_W    = LEN_W / 2;
	localparam int DIST_W    = QUO_W / 2;
	localparam int SQ_REM_W  = DIST_W + 2;
	localparam int CFG_IDX_W = 8;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_START_X = cfg_idx_t'(0);
	localparam cfg_idx_t REG_START_Y = cfg_idx_t'(1);
	localparam cfg_idx_t REG_END_X   = cfg_idx_t'(2);
	localparam cfg_idx_t REG_END_Y   = cfg_idx_t'(3);

	typedef enum logic [1:0] {
		PART_START    = 2'd0,
		PART_END      = 2'd1,
		PART_INTERIOR = 2'd2
	} part_t;

	// restoring divider state: partial remainder, dividend bits shifting out
	// at the top while quotient bits shift in at the bottom
	typedef struct packed {
		logic [LEN_W-1:0] rem;
		logic [QUO_W-1:0] low;
		logic [LEN_W-1:0] den;
		part_t            part;
	} div_stage_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [QUO_W-1:0]    rad;
		logic [DIST_W-1:0]   root;
		part_t               part;
	} sqrt_stage_t;

	function automatic div_stage_t div_step(div_stage_t s);
		div_stage_t     r;
		logic [LEN_W:0] t;
		logic           ge;
		t = {s.rem, s.low[QUO_W-1]};
		ge = (t >= {1'b0, s.den});
		r = s;
		r.rem = ge ? LEN_W'(t - {1'b0, s.den}) : t[LEN_W-1:0];
		r.low = {s.low[QUO_W-2:0], ge};
		return r;
	endfunction

	function automatic sqrt_stage_t sqrt_step(sqrt_stage_t s);
		sqrt_stage_t         r;
		logic [SQ_REM_W+1:0] t;
		logic [SQ_REM_W+1:0] trial;
		logic                ge;
		t = {s.rem, s.rad[QUO_W-1 -: 2]};
		trial = {2'b00, s.root, 2'b01};
		ge = (t >= trial);
		r = s;
		r.rem = ge ? SQ_REM_W'(t - trial) : t[SQ_REM_W-1:0];
		r.root = {s.root[DIST_W-2:0], ge};
		r.rad = {s.rad[QUO_W-3:0], 2'b00};
		return r;
	endfunction

endpackage

[src/point_segment_distance.sv]
// Point to segment distance engine.
// Input channel (in_valid/in_ready) carries one query point per transaction;
// output channel (out_valid/out_ready) returns floor(distance) and the part of
// the segment that is nearest (first endpoint, second endpoint or interior).
// The segment endpoints are written through the cfg channel (cfg_index 0..3:
// start x, start y, end x, end y); indexes beyond that are dropped. cfg_ready
// is always high. Write the endpoints only while no transaction is in flight,
// and allow three cycles for the segment length to settle before the next
// query.
// Pipeline: 5 front stages, 34 divider stages and 17 square root stages.
// Throughput: one transaction per cycle while the receiver keeps out_ready
// high, set by the one-bit-per-stage divider and root pipelines.
// Reset clears all stage valid bits and the segment registers to zero.
// When the receiver stalls, each stage holds only if the stage after it is
// full, so bubbles collapse and in_ready drops only once the whole pipe is
// backed up behind the held result.
module point_segment_distance (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [psd_pkg::COORD_W-1:0]  query_x,
	input  logic signed [psd_pkg::COORD_W-1:0]  query_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [psd_pkg::DIST_W-1:0]   distance,
	output logic        [1:0]                   nearest_part,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic        [psd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [psd_pkg::COORD_W-1:0]  cfg_data
);
	import psd_pkg::*;

	// segment registers and derived constants
	logic signed [COORD_W-1:0] seg_start_x_q, seg_start_y_q, seg_end_x_q, seg_end_y_q;
	logic signed [DIFF_W-1:0]  cx_q, cy_q;
	logic        [LEN_W-1:0]   cxx_q, cyy_q, len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_start_x_q <= '0;
			seg_start_y_q <= '0;
			seg_end_x_q   <= '0;
			seg_end_y_q   <= '0;
			cx_q          <= '0;
			cy_q          <= '0;
			cxx_q         <= '0;
			cyy_q         <= '0;
			len_q         <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_START_X: seg_start_x_q <= cfg_data;
					REG_START_Y: seg_start_y_q <= cfg_data;
					REG_END_X:   seg_end_x_q   <= cfg_data;
					REG_END_Y:   seg_end_y_q   <= cfg_data;
					default: ;
				endcase
			end
			// direction and squared length follow the endpoints through the cx/cy, cxx/cyy and len registers
			cx_q  <= $signed({seg_end_x_q[COORD_W-1], seg_end_x_q})
			       - $signed({seg_start_x_q[COORD_W-1], seg_start_x_q});
			cy_q  <= $signed({seg_end_y_q[COORD_W-1], seg_end_y_q})
			       - $signed({seg_start_y_q[COORD_W-1], seg_start_y_q});
			cxx_q <= cx_q * cx_q;
			cyy_q <= cy_q * cy_q;
			len_q <= cxx_q + cyy_q;
		end
	end

	assign cfg_ready = 1'b1;

	// front pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	logic div_in_ready;

	assign en5 = !v_s5 || div_in_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1: offsets from both endpoints
	logic signed [DIFF_W-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	// stage 2: all products
	logic signed [PROD_W-1:0] dotx_s2, doty_s2, cra_s2, crb_s2;
	logic signed [PROD_W-1:0] sqax_s2, sqay_s2, sqbx_s2, sqby_s2;
	// stage 3: dot product, cross magnitude, endpoint squared distances
	logic signed [DOT_W-1:0]  dot_s3;
	logic        [LEN_W-1:0]  crm_s3, sqa_s3, sqb_s3;
	// stage 4: region decision and partial products of the cross squared
	part_t                    part_s4;
	logic        [LEN_W-1:0]  sq_s4, hh_s4, hl_s4, ll_s4;
	// stage 5: divider operands
	div_stage_t               div_in_s5;

	logic signed [DOT_W-1:0]  cross_c;
	logic        [DOT_W-1:0]  cross_abs_c;
	logic        [HALF_W-1:0] cr_hi_c, cr_lo_c;
	part_t                    part_c;
	logic        [NUM_W-1:0]  num_c;

	always_comb begin
		cross_c     = DOT_W'(cra_s2) - DOT_W'(crb_s2);
		cross_abs_c = cross_c[DOT_W-1] ? DOT_W'(-cross_c) : DOT_W'(cross_c);
		cr_hi_c     = crm_s3[LEN_W-1:HALF_W];
		cr_lo_c     = crm_s3[HALF_W-1:0];
		if (dot_s3[DOT_W-1] || dot_s3 == '0) begin
			part_c = PART_START;
		end else if (dot_s3[LEN_W-1:0] >= len_q) begin
			part_c = PART_END;
		end else begin
			part_c = PART_INTERIOR;
		end
		// cross^2 rebuilt from its halves
		num_c = (NUM_W'(hh_s4) << (2 * HALF_W)) + (NUM_W'(hl_s4) << (HALF_W + 1))
		      + NUM_W'(ll_s4);
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ax_s1 <= $signed({query_x[COORD_W-1], query_x})
			       - $signed({seg_start_x_q[COORD_W-1], seg_start_x_q});
			ay_s1 <= $signed({query_y[COORD_W-1], query_y})
			       - $signed({seg_start_y_q[COORD_W-1], seg_start_y_q});
			bx_s1 <= $signed({query_x[COORD_W-1], query_x})
			       - $signed({seg_end_x_q[COORD_W-1], seg_end_x_q});
			by_s1 <= $signed({query_y[COORD_W-1], query_y})
			       - $signed({seg_end_y_q[COORD_W-1], seg_end_y_q});
		end
		if (en2) begin
			dotx_s2 <= ax_s1 * cx_q;
			doty_s2 <= ay_s1 * cy_q;
			cra_s2  <= ax_s1 * cy_q;
			crb_s2  <= ay_s1 * cx_q;
			sqax_s2 <= ax_s1 * ax_s1;
			sqay_s2 <= ay_s1 * ay_s1;
			sqbx_s2 <= bx_s1 * bx_s1;
			sqby_s2 <= by_s1 * by_s1;
		end
		if (en3) begin
			dot_s3 <= DOT_W'(dotx_s2) + DOT_W'(doty_s2);
			crm_s3 <= cross_abs_c[LEN_W-1:0];
			sqa_s3 <= LEN_W'(sqax_s2) + LEN_W'(sqay_s2);
			sqb_s3 <= LEN_W'(sqbx_s2) + LEN_W'(sqby_s2);
		end
		if (en4) begin
			part_s4 <= part_c;
			sq_s4   <= (part_c == PART_START) ? sqa_s3 : sqb_s3;
			hh_s4   <= cr_hi_c * cr_hi_c;
			hl_s4   <= cr_hi_c * cr_lo_c;
			ll_s4   <= cr_lo_c * cr_lo_c;
		end
		if (en5) begin
			// endpoint case divides the squared distance by one
			div_in_s5.part <= part_s4;
			if (part_s4 == PART_INTERIOR) begin
				div_in_s5.rem <= num_c[NUM_W-1:QUO_W];
				div_in_s5.low <= num_c[QUO_W-1:0];
				div_in_s5.den <= len_q;
			end else begin
				div_in_s5.rem <= '0;
				div_in_s5.low <= sq_s4;
				div_in_s5.den <= LEN_W'(1);
			end
		end
	end

	// squared distance, then floor root
	logic        div_out_valid, sq_in_ready;
	div_stage_t  div_out;
	sqrt_stage_t sq_in, sq_out;

	psd_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (div_in_ready),
		.in_stage  (div_in_s5),
		.out_valid (div_out_valid),
		.out_ready (sq_in_ready),
		.out_stage (div_out)
	);

	always_comb begin
		sq_in.rem  = '0;
		sq_in.rad  = div_out.low;
		sq_in.root = '0;
		sq_in.part = div_out.part;
	end

	psd_isqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_out_valid),
		.in_ready  (sq_in_ready),
		.in_stage  (sq_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_stage (sq_out)
	);

	assign distance     = sq_out.root;
	assign nearest_part = sq_out.part;

endmodule

[src/psd_divider.sv]
module psd_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  psd_pkg::div_stage_t in_stage,
	output logic                out_valid,
	input  logic                out_ready,
	output psd_pkg::div_stage_t out_stage
);
	import psd_pkg::*;

	localparam int STAGES = QUO_W;

	logic [STAGES-1:0] vld_sn;
	logic [STAGES-1:0] en;
	div_stage_t        data_sn [STAGES];
	div_stage_t        nxt     [STAGES];

	// one quotient bit per stage
	always_comb begin
		en[STAGES-1] = !vld_sn[STAGES-1] || out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_sn[k] || en[k+1];
		end
		nxt[0] = div_step(in_stage);
		for (int k = 1; k < STAGES; k++) begin
			nxt[k] = div_step(data_sn[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else begin
			if (en[0]) begin
				vld_sn[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					vld_sn[k] <= vld_sn[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < STAGES; k++) begin
			if (en[k]) begin
				data_sn[k] <= nxt[k];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_sn[STAGES-1];
	assign out_stage = data_sn[STAGES-1];

endmodule

[src/psd_isqrt.sv]
module psd_isqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  psd_pkg::sqrt_stage_t in_stage,
	output logic                 out_valid,
	input  logic                 out_ready,
	output psd_pkg::sqrt_stage_t out_stage
);
	import psd_pkg::*;

	localparam int STAGES = DIST_W;

	logic [STAGES-1:0] vld_sn;
	logic [STAGES-1:0] en;
	sqrt_stage_t       data_sn [STAGES];
	sqrt_stage_t       nxt     [STAGES];

	// one root bit per stage, two radicand bits consumed each step
	always_comb begin
		en[STAGES-1] = !vld_sn[STAGES-1] || out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_sn[k] || en[k+1];
		end
		nxt[0] = sqrt_step(in_stage);
		for (int k = 1; k < STAGES; k++) begin
			nxt[k] = sqrt_step(data_sn[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else begin
			if (en[0]) begin
				vld_sn[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					vld_sn[k] <= vld_sn[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < STAGES; k++) begin
			if (en[k]) begin
				data_sn[k] <= nxt[k];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_sn[STAGES-1];
	assign out_stage = data_sn[STAGES-1];

endmodule

[src/psd_checker.sv]
module psd_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic signed [psd_pkg::COORD_W-1:0]   query_x,
	input logic signed [psd_pkg::COORD_W-1:0]   query_y,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic        [psd_pkg::DIST_W-1:0]    distance,
	input logic        [1:0]                    nearest_part,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready,
	input logic        [psd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic        [psd_pkg::COORD_W-1:0]   cfg_data
);
	import psd_pkg::*;

	// held result stays presented
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(distance) && $stable(nearest_part))
		else $error("result changed while stalled");

	// input backpressure only when the pipe is full behind a held result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	a_part_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> nearest_part == PART_START || nearest_part == PART_END
			|| nearest_part == PART_INTERIOR)
		else $error("bad nearest part code");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance <= DIST_W'(92681))
		else $error("distance out of range");

endmodule

bind point_segment_distance psd_checker u_psd_checker (.*);

[tb/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psd_pkg::*;

	localparam int N_RANDOM = 760;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [COORD_W-1:0] query_x = '0;
	logic signed [COORD_W-1:0] query_y = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [DIST_W-1:0]         distance;
	logic [1:0]                nearest_part;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	cfg_idx_t                  cfg_index = '0;
	logic [COORD_W-1:0]        cfg_data = '0;

	// segment as the checker sees it; follows every accepted register write
	longint seg_x0, seg_y0, seg_x1, seg_y1, seg_len_sq;

	typedef struct {
		logic [DIST_W-1:0] dval;
		part_t             part;
	} answer_t;

	answer_t answer_q[$];
	int      n_errors = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;

	point_segment_distance u_top (.*);

	always #1 clk = ~clk;

	// Hold reset at the start, never again.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Stall the result channel at the current rate.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic longint floor_sqrt(longint n);
		longint r, t;
		r = 0;
		for (int b = COORD_W; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	// Exact point to segment distance against the current segment.
	function automatic answer_t nearest_distance(longint qx, longint qy);
		answer_t     res;
		longint      ax, ay, bx, by, cx, cy, dot, cr, r, t;
		logic [127:0] cr_sq, lhs;
		ax = qx - seg_x0;
		ay = qy - seg_y0;
		bx = qx - seg_x1;
		by = qy - seg_y1;
		cx = seg_x1 - seg_x0;
		cy = seg_y1 - seg_y0;
		dot = ax * cx + ay * cy;
		if (dot <= 0) begin
			res.dval = DIST_W'(floor_sqrt(ax * ax + ay * ay));
			res.part = PART_START;
		end else if (dot >= seg_len_sq) begin
			res.dval = DIST_W'(floor_sqrt(bx * bx + by * by));
			res.part = PART_END;
		end else begin
			// largest d with d^2 * |c|^2 <= cross^2, widened to avoid overflow
			cr = ax * cy - ay * cx;
			if (cr < 0)
				cr = -cr;
			cr_sq = 128'(cr) * 128'(cr);
			r = 0;
			for (int b = COORD_W; b >= 0; b--) begin
				t = r | (longint'(1) << b);
				lhs = 128'(t * t) * 128'(seg_len_sq);
				if (lhs <= cr_sq)
					r = t;
			end
			res.dval = DIST_W'(r);
			res.part = PART_INTERIOR;
		end
		return res;
	endfunction

	// Track register writes and queue an answer for every accepted query;
	// check every accepted result against the oldest queued answer.
	always @(posedge clk) begin
		answer_t got, want;
		if (!arst_n) begin
			seg_x0 = 0; seg_y0 = 0; seg_x1 = 0; seg_y1 = 0; seg_len_sq = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_START_X: seg_x0 = longint'($signed(cfg_data));
					REG_START_Y: seg_y0 = longint'($signed(cfg_data));
					REG_END_X:   seg_x1 = longint'($signed(cfg_data));
					REG_END_Y:   seg_y1 = longint'($signed(cfg_data));
					default: ;
				endcase
				seg_len_sq = (seg_x1 - seg_x0) * (seg_x1 - seg_x0)
					+ (seg_y1 - seg_y0) * (seg_y1 - seg_y0);
			end
			if (in_valid && in_ready)
				answer_q.push_back(nearest_distance(longint'(query_x), longint'(query_y)));
			if (out_valid && out_ready) begin
				got.dval = distance;
				got.part = part_t'(nearest_part);
				if (answer_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected result: distance %0d part %0d", got.dval, got.part);
				end else begin
					want = answer_q.pop_front();
					if (got.dval !== want.dval || got.part !== want.part) begin
						n_errors++;
						if (n_errors <= 10)
							$display("mismatch: distance exp %0d got %0d, part exp %0d got %0d",
								want.dval, got.dval, want.part, got.part);
					end
				end
			end
		end
	end

	// Hold valid until the write lands; the caller drops it after the group.
	task automatic write_reg(cfg_idx_t idx, logic [COORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Wait for every queued answer, then let the segment length settle.
	task automatic drain();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Send one query transaction, idling each cycle at the current rate first.
	task automatic send_query(logic [COORD_W-1:0] qx, logic [COORD_W-1:0] qy);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		query_x  <= qx;
		query_y  <= qy;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic set_segment(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
		logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1);
		drain();
		write_reg(REG_START_X, x0);
		write_reg(REG_START_Y, y0);
		write_reg(REG_END_X, x1);
		write_reg(REG_END_Y, y1);
		cfg_valid <= 1'b0;
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		return COORD_W'($urandom);
	endfunction

	// Mostly small segments, sometimes full range or the extreme corners.
	function automatic logic [COORD_W-1:0] rand_endpoint();
		case ($urandom_range(3))
			0: return rand_coord();
			1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
			default: return COORD_W'($signed($urandom_range(4000)) - 2000);
		endcase
	endfunction

	typedef enum logic [1:0] {ROW_QUERY, ROW_CFG, ROW_CHECK} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [COORD_W-1:0] a;
		logic [COORD_W-1:0] b;
		logic [DIST_W-1:0]  dval;
		part_t              part;
	} row_t;

	// Directed stimulus: query rows run through the checker's model, check rows
	// also carry a hand-read answer, cfg rows write register a with data b.
	row_t dir_rows[] = '{
		'{ROW_CHECK, 16'h0000, 16'h0000, 17'd0,     PART_START},
		'{ROW_CHECK, 16'h8000, 16'h8000, 17'd46340, PART_START},
		'{ROW_CHECK, 16'h7fff, 16'h7fff, 17'd46339, PART_START},
		'{ROW_CFG,   16'd4,    16'h1234, 17'd0,     PART_START},
		'{ROW_CFG,   16'd255,  16'hffff, 17'd0,     PART_START},
		'{ROW_CHECK, 16'd16,   16'h0000, 17'd16,    PART_START},
		'{ROW_CFG,   16'd0,    16'h8000, 17'd0,     PART_START},
		'{ROW_CFG,   16'd1,    16'h8000, 17'd0,     PART_START},
		'{ROW_CFG,   16'd2,    16'h7fff, 17'd0,     PART_START},
		'{ROW_CFG,   16'd3,    16'h7fff, 17'd0,     PART_START},
		'{ROW_CHECK, 16'h8000, 16'h8000, 17'd0,     PART_START},
		'{ROW_CHECK, 16'h7fff, 16'h7fff, 17'd0,     PART_END},
		'{ROW_QUERY, 16'h7fff, 16'h8000, 17'd0,     PART_START},
		'{ROW_QUERY, 16'h8000, 16'h7fff, 17'd0,     PART_START},
		'{ROW_QUERY, 16'h0000, 16'h0000, 17'd0,     PART_START},
		'{ROW_CFG,   16'd0,    16'h0000, 17'd0,     PART_START},
		'{ROW_CFG,   16'd1,    16'h0000, 17'd0,     PART_START},
		'{ROW_CFG,   16'd2,    16'd160,  17'd0,     PART_START},
		'{ROW_CFG,   16'd3,    16'h0000, 17'd0,     PART_START},
		'{ROW_CHECK, 16'd80,   16'd48,   17'd48,    PART_INTERIOR},
		'{ROW_CHECK, -16'sd30, 16'd40,   17'd50,    PART_START},
		'{ROW_CHECK, 16'd190,  -16'sd40, 17'd50,    PART_END},
		'{ROW_CHECK, 16'd160,  16'h0000, 17'd0,     PART_END},
		'{ROW_CFG,   16'd3,    -16'sd320, 17'd0,    PART_START},
		'{ROW_QUERY, 16'd5,    -16'sd100, 17'd0,    PART_START}
	};

	logic              dir_check = 1'b0;
	logic [DIST_W-1:0] dir_dist = '0;
	part_t             dir_part = PART_START;

	// Hand-read answers are checked on top of the model, against the model.
	always @(posedge clk)
		if (in_valid && in_ready && dir_check) begin
			answer_t m;
			m = nearest_distance(longint'(query_x), longint'(query_y));
			if (m.dval !== dir_dist || m.part !== dir_part) begin
				n_errors++;
				if (n_errors <= 10)
					$display("directed answer: expected %0d/%0d, model gives %0d/%0d",
						dir_dist, dir_part, m.dval, m.part);
			end
		end

	initial begin
		int         n_sent;
		int         mode;
		logic [COORD_W-1:0] qx, qy, x0, y0, x1, y1;
		int         frac;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		@(posedge clk);

		// directed part
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(cfg_idx_t'(dir_rows[i].a), dir_rows[i].b);
				cfg_valid <= 1'b0;
				repeat (3) @(posedge clk);
			end else begin
				dir_check <= (dir_rows[i].kind == ROW_CHECK);
				dir_dist  <= dir_rows[i].dval;
				dir_part  <= dir_rows[i].part;
				send_query(dir_rows[i].a, dir_rows[i].b);
			end
		end
		dir_check <= 1'b0;

		// random part: four traffic modes, new segment every 40 queries
		n_sent = 0;
		for (mode = 0; mode < 4; mode++) begin
			drain();
			case (mode)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			for (int k = 0; k < N_RANDOM / 4; k++) begin
				if (k % 40 == 0) begin
					x0 = rand_endpoint(); y0 = rand_endpoint();
					x1 = rand_endpoint(); y1 = rand_endpoint();
					if ($urandom_range(9) == 0) begin
						x1 = x0; y1 = y0;
					end
					set_segment(x0, y0, x1, y1);
				end
				// pause until the pipe is empty once per mode
				if (k == 100)
					drain();
				case ($urandom_range(3))
					0: begin
						qx = rand_coord();
						qy = rand_coord();
					end
					1: begin
						// near an endpoint
						qx = ($urandom_range(1) ? x0 : x1) + COORD_W'($urandom_range(64)) - 16'd32;
						qy = ($urandom_range(1) ? y0 : y1) + COORD_W'($urandom_range(64)) - 16'd32;
					end
					default: begin
						// beside the segment, sometimes past its ends
						frac = int'($urandom_range(160)) - 30;
						qx = COORD_W'(longint'($signed(x0)) + (longint'($signed(x1))
							- longint'($signed(x0))) * frac / 100
							+ int'($urandom_range(200)) - 100);
						qy = COORD_W'(longint'($signed(y0)) + (longint'($signed(y1))
							- longint'($signed(y0))) * frac / 100
							+ int'($urandom_range(200)) - 100);
					end
				endcase
				send_query(qx, qy);
				n_sent++;
			end
		end

		drain();
		repeat (60) @(posedge clk);
		if (n_errors == 0 && answer_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#1000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
